// ===== design/hcd_pkg.sv =====
// Package for the HTTP chunked body decoder: phase and status codes,
// character constants and the hex digit decoder. No dependencies.
package hcd_pkg;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_DATA = 2'd1,
    PH_SKIP = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;

  localparam logic [1:0] SKIP_LEN = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== design/http_chunked_decoder_unit.sv =====
// HTTP/1.1 chunked transfer decoder, top level.
// Depends on hcd_pkg.
//
// Usage:
//   Input channel in_*: one raw body byte per item in in_tdata, in_tlast
//   marks the last byte of the received body.
//   Result channel out_*: out_tdata carries the payload byte, out_tuser the
//   status (0 data byte, 1 terminal chunk reached, 2 malformed body). An
//   input item gives zero or one result item; unless in_tlast is set, a size
//   line gives at most a status on its LF and the two bytes after a chunk none.
//   Latency: a result is presented the cycle after its input item is taken.
//   Throughput: one byte per cycle when not stalled; the decode of a byte is one
//   pass of logic from the state registers into the result register.
//   Stall: the result register holds while out_tready is low; a new byte is
//   still taken when the result register is empty or is drained that cycle.
//   Reset: the decoder starts at a size line with no result pending. After
//   any byte with in_tlast set it returns to a size line for the next body.
module http_chunked_decoder_unit
  import hcd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser   // [1:0] status
);

  phase_t               phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] chunk_r, chunk_nxt;
  logic                 closed_r, closed_nxt;
  logic                 saw_r, saw_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 cr_r, cr_nxt;
  logic [1:0]           skip_r, skip_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  status_t              out_status_r;

  logic                 in_fire;
  logic                 res_valid;
  status_t              res_status;
  logic [7:0]           res_byte;
  hex_t                 hex;
  logic [SIZE_BITS-1:0] chunk_dec;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign hex       = hex_decode(in_tdata);
  assign chunk_dec = chunk_r - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIZE;
      chunk_r  <= '0;
      closed_r <= 1'b0;
      saw_r    <= 1'b0;
      ovf_r    <= 1'b0;
      cr_r     <= 1'b0;
      skip_r   <= 2'd0;
    end else begin
      phase_r  <= phase_nxt;
      chunk_r  <= chunk_nxt;
      closed_r <= closed_nxt;
      saw_r    <= saw_nxt;
      ovf_r    <= ovf_nxt;
      cr_r     <= cr_nxt;
      skip_r   <= skip_nxt;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    chunk_nxt  = chunk_r;
    closed_nxt = closed_r;
    saw_nxt    = saw_r;
    ovf_nxt    = ovf_r;
    cr_nxt     = cr_r;
    skip_nxt   = skip_r;
    res_valid  = 1'b0;
    res_status = ST_DATA;
    res_byte   = 8'd0;
    if (in_fire) begin
      unique case (phase_r)
        PH_SIZE: begin
          if (cr_r && in_tdata == CHAR_LF) begin
            if (ovf_r) begin
              res_valid  = 1'b1;
              res_status = ST_BAD;
              phase_nxt  = PH_END;
            end else if (!saw_r || chunk_r == '0) begin
              res_valid  = 1'b1;
              res_status = ST_DONE;
              phase_nxt  = PH_END;
            end else begin
              phase_nxt = PH_DATA;
            end
            closed_nxt = 1'b0;
            saw_nxt    = 1'b0;
            ovf_nxt    = 1'b0;
            cr_nxt     = 1'b0;
          end else begin
            if (!closed_r) begin
              if (hex.valid) begin
                saw_nxt = 1'b1;
                if (!ovf_r) begin
                  if (|chunk_r[SIZE_BITS-1 -: 4]) begin
                    ovf_nxt = 1'b1;
                  end else begin
                    chunk_nxt = {chunk_r[SIZE_BITS-5:0], hex.value};
                  end
                end
              end else if (!((in_tdata == CHAR_SP || in_tdata == CHAR_TAB) && !saw_r)) begin
                closed_nxt = 1'b1;
              end
            end
            cr_nxt = (in_tdata == CHAR_CR);
          end
        end
        PH_DATA: begin
          res_valid  = 1'b1;
          res_status = ST_DATA;
          res_byte   = in_tdata;
          chunk_nxt  = chunk_dec;
          if (chunk_dec == '0) begin
            phase_nxt = PH_SKIP;
            skip_nxt  = SKIP_LEN;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_r - 2'd1;
          if (skip_r == 2'd1) begin
            phase_nxt  = PH_SIZE;
            chunk_nxt  = '0;
            closed_nxt = 1'b0;
            saw_nxt    = 1'b0;
            ovf_nxt    = 1'b0;
            cr_nxt     = 1'b0;
          end
        end
        PH_END: begin
        end
      endcase
      if (in_tlast) begin
        // early end of body reports malformed, unless this byte gave a final status or the body already ended
        if (!(phase_nxt == PH_END && !res_valid) && !(res_valid && res_status != ST_DATA)) begin
          res_valid  = 1'b1;
          res_status = ST_BAD;
          res_byte   = 8'd0;
        end
        phase_nxt  = PH_SIZE;
        chunk_nxt  = '0;
        skip_nxt   = 2'd0;
        closed_nxt = 1'b0;
        saw_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
        cr_nxt     = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = res_valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_byte_r   <= res_byte;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> chunk_r != '0)
    else $error("data phase with zero chunk count");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> phase_r == PH_SIZE && chunk_r == '0 && !saw_r)
    else $error("state not cleared after end of body");

  a_last_reports: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast && phase_r != PH_END |=> out_valid_r && out_status_r != ST_DATA)
    else $error("end of body gave no final status");

  a_data_from_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && res_valid && res_status == ST_DATA |-> phase_r == PH_DATA)
    else $error("data byte outside data phase");
`endif

endmodule

// ===== tb/sv/http_chunked_decoder_unit_tb.sv =====
// Self-checking testbench for http_chunked_decoder_unit: drives chunked bodies
// and checks every decoded byte and status against a cycle-free predictor.
// Depends on hcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module http_chunked_decoder_unit_tb;
  import hcd_pkg::*;

  localparam int SIZE_BITS = 32;
  localparam int ITEMS_PER_PHASE = 100;

  localparam int LINE_SIZE  = 0;
  localparam int LINE_HUGE  = 1;
  localparam int LINE_BLANK = 2;

  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } body_item_t;

  typedef struct {
    logic [7:0] data;
    status_t    status;
  } chunk_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;

  body_item_t    body_bytes[$];
  chunk_result_t decoded_results[$];
  body_item_t    next_item;
  chunk_result_t want;
  int            mismatches = 0;
  int            sender_idle_pct = 0;
  int            stall_pct = 0;
  string         hex_chars = "0123456789abcdefABCDEF";

  // predictor state
  phase_t               dec_phase;
  logic [SIZE_BITS-1:0] dec_remaining;
  bit                   dec_closed;
  bit                   dec_seen_digit;
  bit                   dec_too_big;
  bit                   dec_after_cr;
  logic [1:0]           dec_skip_left;

  http_chunked_decoder_unit #(.SIZE_BITS(SIZE_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  task automatic clear_size_line();
    dec_closed = 1'b0;
    dec_seen_digit = 1'b0;
    dec_too_big = 1'b0;
    dec_after_cr = 1'b0;
  endtask

  task automatic reset_decoder();
    dec_phase = PH_SIZE;
    dec_remaining = '0;
    dec_skip_left = '0;
    clear_size_line();
  endtask

  task automatic decode_chunked_byte(input logic [7:0] c, input logic last);
    chunk_result_t r;
    bit produced;
    int hv;
    r.data = 8'h00;
    r.status = ST_DATA;
    produced = 1'b0;
    case (dec_phase)
      PH_SIZE: begin
        if (dec_after_cr && c == CHAR_LF) begin
          if (dec_too_big) begin
            r.status = ST_BAD;
            produced = 1'b1;
            dec_phase = PH_END;
          end else if (!dec_seen_digit || dec_remaining == '0) begin
            r.status = ST_DONE;
            produced = 1'b1;
            dec_phase = PH_END;
          end else begin
            dec_phase = PH_DATA;
          end
          clear_size_line();
        end else begin
          if (!dec_closed) begin
            hv = hex_digit(c);
            if (hv >= 0) begin
              dec_seen_digit = 1'b1;
              if (!dec_too_big) begin
                if (dec_remaining[SIZE_BITS-1 -: 4] != 4'd0) begin
                  dec_too_big = 1'b1;
                end else begin
                  dec_remaining = {dec_remaining[SIZE_BITS-5:0], hv[3:0]};
                end
              end
            end else if (!((c == CHAR_SP || c == CHAR_TAB) && !dec_seen_digit)) begin
              dec_closed = 1'b1;
            end
          end
          dec_after_cr = (c == CHAR_CR);
        end
      end
      PH_DATA: begin
        r.data = c;
        produced = 1'b1;
        dec_remaining = dec_remaining - SIZE_BITS'(1);
        if (dec_remaining == '0) begin
          dec_phase = PH_SKIP;
          dec_skip_left = SKIP_LEN;
        end
      end
      PH_SKIP: begin
        dec_skip_left = dec_skip_left - 2'd1;
        if (dec_skip_left == 2'd0) begin
          dec_phase = PH_SIZE;
          dec_remaining = '0;
          clear_size_line();
        end
      end
      default: begin
      end
    endcase
    // body end: anything short of a finished terminal line is malformed
    if (last) begin
      if (!(dec_phase == PH_END && !produced) && !(produced && r.status != ST_DATA)) begin
        r.status = ST_BAD;
        r.data = 8'h00;
        produced = 1'b1;
      end
      reset_decoder();
    end
    if (produced) decoded_results.push_back(r);
  endtask

  task automatic push_byte(input logic [7:0] c);
    body_item_t it;
    it.data = c;
    it.last = 1'b0;
    body_bytes.push_back(it);
  endtask

  task automatic push_crlf();
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
  endtask

  task automatic push_text(input string s);
    foreach (s[i]) push_byte(s[i]);
  endtask

  task automatic mark_body_end();
    body_bytes[body_bytes.size() - 1].last = 1'b1;
  endtask

  task automatic add_size_line(input int unsigned size, input int mode);
    string digits;
    logic [7:0] c;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte($urandom_range(1) ? CHAR_SP : CHAR_TAB);
    end
    if (mode == LINE_HUGE) begin
      push_byte(hex_chars[$urandom_range(1, 21)]);
      repeat ($urandom_range(8, 9)) push_byte(hex_chars[$urandom_range(21)]);
    end else if (mode == LINE_SIZE) begin
      if ($urandom_range(4) == 0) push_byte("0");
      digits = $sformatf("%0h", size);
      foreach (digits[i]) begin
        c = digits[i];
        if (c >= "a" && $urandom_range(1)) c = c - 8'h20;
        push_byte(c);
      end
    end
    if ((mode == LINE_BLANK && $urandom_range(1)) || $urandom_range(4) == 0) begin
      push_byte(CHAR_SEMI);
      repeat ($urandom_range(0, 4)) begin
        c = 8'($urandom_range(255));
        push_byte(c == CHAR_LF ? CHAR_SEMI : c);
      end
    end
    push_crlf();
  endtask

  task automatic add_random_body();
    int kind;
    int start;
    int keep;
    int unsigned size;
    kind = $urandom_range(99);
    start = body_bytes.size();
    if (kind < 10) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(0, 3)) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 6);
        add_size_line(size, LINE_SIZE);
        repeat (size) push_byte(8'($urandom_range(255)));
        if ($urandom_range(7) == 0) begin
          push_byte(8'($urandom_range(255)));
          push_byte(8'($urandom_range(255)));
        end else begin
          push_crlf();
        end
      end
      if (kind < 20) add_size_line(0, LINE_HUGE);
      else if ($urandom_range(4) == 0) add_size_line(0, LINE_BLANK);
      else add_size_line(0, LINE_SIZE);
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(255)));
      end
      if (kind >= 20 && kind < 35) begin
        keep = $urandom_range(1, body_bytes.size() - start);
        while (body_bytes.size() > start + keep) void'(body_bytes.pop_back());
      end
    end
    mark_body_end();
  endtask

  task automatic wait_drained(input int limit);
    int n;
    n = 0;
    while ((body_bytes.size() != 0 || in_tvalid || decoded_results.size() != 0) &&
           (limit == 0 || n < limit)) begin
      @(posedge clk);
      n++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (body_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_item = body_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= next_item.data;
        in_tlast <= next_item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (decoded_results.size() == 0) begin
          $error("unexpected result: out_byte %02h status %0d", out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = decoded_results.pop_front();
          if (out_tdata !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_tdata);
            mismatches++;
          end
          if (out_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tuser);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_chunked_byte(in_tdata, in_tlast);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    reset_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // tab before size, lone CR in the line, 0xFF payload, terminal chunk,
    // then a 0x00 byte after the end
    push_byte(CHAR_TAB);
    push_text("1");
    push_byte(CHAR_CR);
    push_text("z");
    push_crlf();
    push_byte(8'hFF);
    push_crlf();
    push_text("0");
    push_crlf();
    push_byte(8'h00);
    mark_body_end();
    // size overflow, mixed-case digits
    push_text("aBcDeF012");
    push_crlf();
    mark_body_end();
    // body ends right after the chunk data, before its CRLF
    push_text("2");
    push_crlf();
    push_text("AB");
    mark_body_end();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin sender_idle_pct <= 79; stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  stall_pct <= 79; end
        default: begin sender_idle_pct <= 37; stall_pct <= 37; end
      endcase
      while (body_bytes.size() < ITEMS_PER_PHASE) add_random_body();
      wait_drained(0);
    end

    wait_drained(5000);
    repeat (4) @(posedge clk);
    if (decoded_results.size() != 0) begin
      $error("%0d expected results never arrived", decoded_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
